FILE: rtl/kcec_pkg.sv
// Shared types and constants for the key click event classifier.
`default_nettype none

package kcec_pkg;

    localparam int KEY_COUNT = 16;
    localparam int TIMER_W   = 16;
    localparam int TICK_W    = 10;
    localparam int KEY_IDX_W = 4;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    typedef enum logic [1:0] {
        EV_SHORT  = 2'd0,
        EV_LONG   = 2'd1,
        EV_DOUBLE = 2'd2
    } event_kind_t;

    typedef enum logic [1:0] {
        REG_TICK_MS         = 2'd0,
        REG_LONG_PRESS_MS   = 2'd1,
        REG_DOUBLE_CLICK_MS = 2'd2
    } cfg_index_t;

    // Event one lane found for the current tick.
    typedef struct packed {
        logic        valid;
        event_kind_t kind;
    } lane_event_t;

    // Timer add, saturating at the top of the timer range.
    function automatic logic [TIMER_W-1:0] sat_add(
        input logic [TIMER_W-1:0] a,
        input logic [TICK_W-1:0]  b
    );
        logic [TIMER_W:0] s;
        s = {1'b0, a} + {{(TIMER_W + 1 - TICK_W){1'b0}}, b};
        return s[TIMER_W] ? TIMER_MAX : s[TIMER_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/key_click_event_classifier.sv
// Top level of the key click event classifier: config registers, key lanes, event merge.
`default_nettype none

// Each accepted s_ request is one scan tick with a pressed-key mask. All sixteen key
// lanes update their timers in the cycle of acceptance, and the events of that tick
// go out on the m_ side one per cycle unless m_tready stalls them, in ascending key
// order, with m_tlast on the final one; a tick with no events produces nothing. A
// tick is taken when the previous tick's events are all sent or the last of them is
// moving to the output register, so ticks without events can follow every cycle.
// The event merge stage with its single output register sets this pace.
// Configuration writes should land only while no events are pending.
module key_click_event_classifier (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] pressed_mask
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [3:0] key_index, [5:4] event_kind, [7:6] zero
    output logic             m_tlast,   // last_event
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import kcec_pkg::*;

    logic [TICK_W-1:0]  tick_ms_reg;
    logic [TIMER_W-1:0] long_press_reg;
    logic [TIMER_W-1:0] double_click_reg;

    lane_event_t [KEY_COUNT-1:0] lane_events;
    logic                        tick_accept;
    logic [KEY_IDX_W-1:0]        ev_key;
    event_kind_t                 ev_kind;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_ms_reg      <= TICK_W'(10);
            long_press_reg   <= TIMER_W'(1000);
            double_click_reg <= TIMER_W'(300);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                REG_TICK_MS:         tick_ms_reg      <= cfg_data[TICK_W-1:0];
                REG_LONG_PRESS_MS:   long_press_reg   <= cfg_data;
                REG_DOUBLE_CLICK_MS: double_click_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign tick_accept = s_tvalid && s_tready;

    for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
        kcec_lane u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .tick_accept (tick_accept),
            .pressed     (s_tdata[k]),
            .tick_ms     (tick_ms_reg),
            .long_thresh (long_press_reg),
            .dbl_window  (double_click_reg),
            .lane_event  (lane_events[k])
        );
    end

    kcec_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick_valid  (s_tvalid),
        .tick_ready  (s_tready),
        .lane_events (lane_events),
        .ev_valid    (m_tvalid),
        .ev_ready    (m_tready),
        .ev_key      (ev_key),
        .ev_kind     (ev_kind),
        .ev_last     (m_tlast)
    );

    assign m_tdata = {2'b00, ev_kind, ev_key};

endmodule

`default_nettype wire

FILE: rtl/kcec_lane.sv
// Per-key state and release classification for one key.
`default_nettype none

module kcec_lane (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            tick_accept,
    input  wire logic                            pressed,
    input  wire logic [kcec_pkg::TICK_W-1:0]     tick_ms,
    input  wire logic [kcec_pkg::TIMER_W-1:0]    long_thresh,
    input  wire logic [kcec_pkg::TIMER_W-1:0]    dbl_window,
    output kcec_pkg::lane_event_t                lane_event
);
    import kcec_pkg::*;

    logic               down_reg, down_next;
    logic               await_reg, await_next;
    logic [TIMER_W-1:0] hold_reg, hold_next;
    logic [TIMER_W-1:0] since_reg, since_next;

    logic               released;
    logic               long_hit;
    logic               dbl_hit;
    logic               start_wait;
    logic               await_mid;
    logic [TIMER_W-1:0] since_mid;
    logic [TIMER_W-1:0] since_adv;

    always_comb begin
        released   = down_reg && !pressed;
        long_hit   = hold_reg >= long_thresh;
        dbl_hit    = released && !long_hit && await_reg && (since_reg < dbl_window);
        start_wait = released && !long_hit && !dbl_hit;
        await_mid  = dbl_hit ? 1'b0 : (start_wait ? 1'b1 : await_reg);
        since_mid  = start_wait ? '0 : since_reg;
        since_adv  = sat_add(since_mid, tick_ms);

        down_next        = down_reg;
        hold_next        = hold_reg;
        await_next       = await_reg;
        since_next       = since_reg;
        lane_event.valid = 1'b0;
        lane_event.kind  = EV_SHORT;

        if (pressed) begin
            down_next = 1'b1;
            hold_next = down_reg ? sat_add(hold_reg, tick_ms) : '0;
        end else begin
            down_next  = 1'b0;
            await_next = await_mid;
            since_next = since_mid;
            if (released && long_hit) begin
                lane_event.valid = 1'b1;
                lane_event.kind  = EV_LONG;
            end else if (dbl_hit) begin
                lane_event.valid = 1'b1;
                lane_event.kind  = EV_DOUBLE;
            end
            if (await_mid) begin
                since_next = since_adv;
                if (since_adv >= dbl_window) begin
                    await_next = 1'b0;
                    // expiry after a short hold, unless this tick already reported
                    if (!long_hit && !(released && long_hit) && !dbl_hit) begin
                        lane_event.valid = 1'b1;
                        lane_event.kind  = EV_SHORT;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            down_reg  <= 1'b0;
            await_reg <= 1'b0;
            hold_reg  <= '0;
            since_reg <= '0;
        end else if (tick_accept) begin
            down_reg  <= down_next;
            await_reg <= await_next;
            hold_reg  <= hold_next;
            since_reg <= since_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/kcec_merge.sv
// Collects the lane events of one tick and sends them out lowest key first.
`default_nettype none

module kcec_merge (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 tick_valid,
    output logic                                      tick_ready,
    input  wire kcec_pkg::lane_event_t [kcec_pkg::KEY_COUNT-1:0] lane_events,
    output logic                                      ev_valid,
    input  wire logic                                 ev_ready,
    output logic [kcec_pkg::KEY_IDX_W-1:0]            ev_key,
    output kcec_pkg::event_kind_t                     ev_kind,
    output logic                                      ev_last
);
    import kcec_pkg::*;

    logic [KEY_COUNT-1:0] pend_reg, pend_next;
    event_kind_t          kind_reg [KEY_COUNT];
    logic                 out_valid_reg, out_valid_next;
    logic [KEY_IDX_W-1:0] out_key_reg;
    event_kind_t          out_kind_reg;
    logic                 out_last_reg;

    logic [KEY_COUNT-1:0] lowest;
    logic [KEY_COUNT-1:0] pend_rest;
    logic [KEY_IDX_W-1:0] low_idx;
    logic                 move;
    logic                 accept;

    // Priority encode the lowest pending key.
    always_comb begin
        low_idx = '0;
        for (int k = KEY_COUNT - 1; k >= 0; k--) begin
            if (pend_reg[k]) begin
                low_idx = KEY_IDX_W'(k);
            end
        end
    end

    always_comb begin
        lowest      = pend_reg & (~pend_reg + KEY_COUNT'(1));
        pend_rest   = pend_reg & ~lowest;
        move        = (pend_reg != '0) && (!out_valid_reg || ev_ready);
        tick_ready  = (pend_reg == '0) || (move && (pend_rest == '0));
        accept      = tick_valid && tick_ready;

        out_valid_next = out_valid_reg && !ev_ready;
        if (move) begin
            out_valid_next = 1'b1;
        end

        pend_next = move ? pend_rest : pend_reg;
        if (accept) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                pend_next[k] = lane_events[k].valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                kind_reg[k] <= lane_events[k].kind;
            end
        end
        if (move) begin
            out_key_reg  <= low_idx;
            out_kind_reg <= kind_reg[low_idx];
            out_last_reg <= (pend_rest == '0);
        end
    end

    assign ev_valid = out_valid_reg;
    assign ev_key   = out_key_reg;
    assign ev_kind  = out_kind_reg;
    assign ev_last  = out_last_reg;

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Testbench for the key click event classifier: directed and random ticks vs a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kcec_pkg::*;

    // Index beyond the register list; the block must ignore writes to it.
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int DRAIN_CYCLES = 24;
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [KEY_IDX_W-1:0] key;
        event_kind_t          kind;
        logic                 last;
    } key_event_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Predictor state: configuration copy and per-key timers.
    logic [TICK_W-1:0]  tick_step;
    logic [TIMER_W-1:0] long_ms;
    logic [TIMER_W-1:0] double_ms;
    logic               key_held [KEY_COUNT];
    logic [TIMER_W-1:0] hold_ms [KEY_COUNT];
    logic               second_pending [KEY_COUNT];
    logic [TIMER_W-1:0] release_ms [KEY_COUNT];

    key_event_t click_events_due[$];
    key_event_t due_event;
    int         mismatch_count = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;

    key_click_event_classifier uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [TIMER_W-1:0] timer_after_tick(
        input logic [TIMER_W-1:0] t,
        input logic [TICK_W-1:0]  step
    );
        return (t > TIMER_MAX - step) ? TIMER_MAX : t + step;
    endfunction

    task automatic flag_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // Work out the events one scan tick causes and queue them.
    task automatic classify_tick(input logic [15:0] mask);
        key_event_t  tick_events [KEY_COUNT];
        int          n_events;
        logic        fired;
        event_kind_t kind;
        n_events = 0;
        for (int k = 0; k < KEY_COUNT; k++) begin
            fired = 1'b0;
            kind = EV_SHORT;
            if (mask[k]) begin
                if (!key_held[k]) begin
                    key_held[k] = 1'b1;
                    hold_ms[k] = '0;
                end else begin
                    hold_ms[k] = timer_after_tick(hold_ms[k], tick_step);
                end
            end else begin
                if (key_held[k]) begin
                    if (hold_ms[k] >= long_ms) begin
                        fired = 1'b1;
                        kind = EV_LONG;
                    end else if (second_pending[k] && release_ms[k] < double_ms) begin
                        second_pending[k] = 1'b0;
                        fired = 1'b1;
                        kind = EV_DOUBLE;
                    end else begin
                        second_pending[k] = 1'b1;
                        release_ms[k] = '0;
                    end
                    key_held[k] = 1'b0;
                end
                if (second_pending[k]) begin
                    release_ms[k] = timer_after_tick(release_ms[k], tick_step);
                    if (release_ms[k] >= double_ms) begin
                        // a long hold already reported gives no short on expiry
                        if (hold_ms[k] < long_ms && !fired) begin
                            fired = 1'b1;
                            kind = EV_SHORT;
                        end
                        second_pending[k] = 1'b0;
                    end
                end
                if (fired) begin
                    tick_events[n_events] = '{key: k[KEY_IDX_W-1:0], kind: kind, last: 1'b0};
                    n_events++;
                end
            end
        end
        if (n_events > 0) begin
            tick_events[n_events-1].last = 1'b1;
        end
        for (int i = 0; i < n_events; i++) begin
            click_events_due.push_back(tick_events[i]);
        end
    endtask

    // Send one scan tick; entered and left at a falling edge, tvalid left high.
    task automatic send_tick(input logic [15:0] mask);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata <= 16'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= mask;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        classify_tick(mask);
        @(negedge aclk);
    endtask

    // Hold off until every queued event has come out and the block has settled.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (click_events_due.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // One register request; cfg_valid is left high for a following request.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_TICK_MS:         tick_step = data[TICK_W-1:0];
            REG_LONG_PRESS_MS:   long_ms = data;
            REG_DOUBLE_CLICK_MS: double_ms = data;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic set_config(
        input logic [15:0] tick,
        input logic [15:0] long_press,
        input logic [15:0] double_click
    );
        wait_idle();
        write_reg(REG_TICK_MS, tick);
        write_reg(REG_LONG_PRESS_MS, long_press);
        write_reg(REG_DOUBLE_CLICK_MS, double_click);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Spare index and upper tick bits must not disturb the registers.
    task automatic test_register_masking();
        wait_idle();
        write_reg(REG_SPARE, 16'hFFFF);
        write_reg(REG_TICK_MS, 16'hFC0A);
        write_reg(REG_LONG_PRESS_MS, 16'd20);
        write_reg(REG_DOUBLE_CLICK_MS, 16'd20);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic test_short_press();
        send_tick(16'h0001);
        send_tick(16'h0000);
        send_tick(16'h0000);
    endtask

    task automatic test_long_press();
        repeat (3) send_tick(16'h8000);
        send_tick(16'h0000);
    endtask

    task automatic test_double_click();
        send_tick(16'h0008);
        send_tick(16'h0000);
        send_tick(16'h0008);
        send_tick(16'h0000);
    endtask

    task automatic test_long_while_waiting();
        send_tick(16'h0020);
        send_tick(16'h0000);
        repeat (3) send_tick(16'h0020);
        send_tick(16'h0000);
    endtask

    task automatic test_all_keys();
        repeat (3) send_tick(16'hFFFF);
        send_tick(16'h0000);
    endtask

    task automatic test_zero_tick();
        set_config(16'd0, 16'd20, 16'd20);
        send_tick(16'h0080);
        send_tick(16'h0000);
        send_tick(16'h0000);
        send_tick(16'h0080);
        send_tick(16'h0000);
    endtask

    task automatic test_zero_thresholds();
        set_config(16'd10, 16'd0, 16'd0);
        send_tick(16'h0200);
        send_tick(16'h0000);
        // zero window alone: waiting ends on the release tick itself
        set_config(16'd10, 16'd1, 16'd0);
        send_tick(16'h0400);
        send_tick(16'h0000);
    endtask

    // Mostly keys toggling with a per-tick flip chance, some fully random masks.
    task automatic random_ticks(input int flip_pct, input int count);
        logic [15:0] held;
        logic [15:0] mask;
        held = 16'($urandom);
        repeat (count) begin
            if ($urandom_range(99) < 10) begin
                mask = 16'($urandom);
            end else begin
                for (int k = 0; k < KEY_COUNT; k++) begin
                    if ($urandom_range(99) < flip_pct) held[k] = ~held[k];
                end
                mask = held;
            end
            send_tick(mask);
        end
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input logic with_saturation);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        set_config(16'd10, 16'd50, 16'd40);
        random_ticks(20, 22);
        set_config(16'd1, 16'd3, 16'd2);
        random_ticks(35, 22);
        set_config(16'd0, 16'd1, 16'd1);
        random_ticks(25, 22);
        set_config(16'd1000, 16'd1, 16'd65535);
        random_ticks(15, 22);
        set_config(16'd7, 16'd0, 16'd0);
        random_ticks(30, 22);
        if (with_saturation) begin
            // long runs so both timers hit the top of their range
            set_config(16'd1023, 16'd65535, 16'd65535);
            random_ticks(1, 80);
        end
    endtask

    // Receiver side: random stalls.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each delivered event with the oldest one due.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (click_events_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected event key %0d kind %0d last %b",
                                        m_tdata[3:0], m_tdata[5:4], m_tlast));
            end else begin
                due_event = click_events_due.pop_front();
                if (m_tdata[3:0] !== due_event.key || m_tdata[5:4] !== due_event.kind ||
                    m_tlast !== due_event.last || m_tdata[7:6] !== 2'b00) begin
                    flag_mismatch($sformatf(
                        "got data %h last %b, expected key %0d kind %0d last %b",
                        m_tdata, m_tlast, due_event.key, due_event.kind, due_event.last));
                end
            end
        end
    end

    initial begin
        tick_step = 10'd10;
        long_ms = 16'd1000;
        double_ms = 16'd300;
        for (int k = 0; k < KEY_COUNT; k++) begin
            key_held[k] = 1'b0;
            hold_ms[k] = '0;
            second_pending[k] = 1'b0;
            release_ms[k] = '0;
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 21;
        recv_idle_pct = 75;
        test_register_masking();
        test_short_press();
        test_long_press();
        test_double_click();
        test_long_while_waiting();
        test_all_keys();
        test_zero_tick();
        test_zero_thresholds();

        test_random_traffic(21, 75, 1'b0);
        test_random_traffic(75, 21, 1'b0);
        test_random_traffic(0, 0, 1'b1);

        wait_idle();
        if (mismatch_count == 0) begin
            $display("** key_click_event_classifier: PASSED **");
        end else begin
            $display("** key_click_event_classifier: FAILED **");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d events still due", click_events_due.size());
        $display("** key_click_event_classifier: FAILED **");
        $finish;
    end

endmodule
